// ===== design/jsbq_pkg.sv =====
// Shared widths, register indexes, state records and helpers for the stick and button qualifier.
`default_nettype none
package jsbq_pkg;

  localparam int TIME_BITS     = 48;
  localparam int AXIS_BITS     = 16;
  localparam int ALPHA_BITS    = 16;
  localparam int DZ_BITS       = 15;
  localparam int HOLD_CNT_BITS = 8;
  localparam int GRIP_BITS     = 16;
  localparam int TICK_BITS     = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int BTN_BITS      = 3;

  // Magnitude of an axis or a level, wide enough for both.
  localparam int MAG_BITS = (AXIS_BITS + 1 > DZ_BITS) ? AXIS_BITS + 1 : DZ_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEADZONE     = 3'd0,
    REG_ALPHA        = 3'd1,
    REG_HOLD_LEVEL   = 3'd2,
    REG_HOLD_LIMIT   = 3'd3,
    REG_GRIP_LEVEL   = 3'd4,
    REG_CLICK_TMO    = 3'd5,
    REG_BLOCK_TIME   = 3'd6
  } cfg_reg_t;

  localparam logic [DZ_BITS-1:0]       DEADZONE_RESET   = DZ_BITS'(3277);
  localparam logic [ALPHA_BITS-1:0]    ALPHA_RESET      = ALPHA_BITS'(32768);
  localparam logic [DZ_BITS-1:0]       HOLD_LEVEL_RESET = DZ_BITS'(26214);
  localparam logic [HOLD_CNT_BITS-1:0] HOLD_LIMIT_RESET = HOLD_CNT_BITS'(100);
  localparam logic [GRIP_BITS-1:0]     GRIP_LEVEL_RESET = GRIP_BITS'(49152);
  localparam logic [TICK_BITS-1:0]     CLICK_TMO_RESET  = TICK_BITS'(300000);
  localparam logic [TICK_BITS-1:0]     BLOCK_TIME_RESET = TICK_BITS'(5000000);

  // Button bit positions.
  localparam int BTN_X = 0;
  localparam int BTN_Y = 1;
  localparam int BTN_A = 2;

  // First click of one button: valid flag and its time or cooldown deadline.
  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] stamp;
  } click_state_t;

  // Last accepted mode change, shared by both arms.
  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] stamp;
  } mode_change_t;

  function automatic logic [MAG_BITS-1:0] axis_mag(input logic signed [AXIS_BITS-1:0] v);
    logic signed [AXIS_BITS:0] w;
    w = {v[AXIS_BITS-1], v};
    if (v[AXIS_BITS-1]) begin
      w = -w;
    end
    return MAG_BITS'(unsigned'(w));
  endfunction

endpackage
`default_nettype wire

// ===== design/joystick_stick_and_button_qualifier.sv =====
// Top level of the stick and button qualifier: sample register, conditioning logic, result register.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   sample_time, four stick axes, two grips, button_bits
// out      out  out_valid / out_ready four filtered axes and six flags
// cfg      in   cfg_valid / cfg_ready cfg_index (register 0..6), cfg_data
//
// One sample per cycle sustained while out_ready holds; a taken beat is registered in the sample
// register, then in the result register. The per-sample path is one 18 x 17 multiply per
// axis plus the chained 48-bit compares of the two click qualifiers.
// rst is synchronous; it restores the register defaults and all qualifier state.
// A stalled result holds the sample register; in_ready stays high while the sample stage
// can move on. cfg_ready is always high.
`default_nettype none
module joystick_stick_and_button_qualifier (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // sample channel
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic        [jsbq_pkg::TIME_BITS-1:0]    sample_time,
  input  wire logic signed [jsbq_pkg::AXIS_BITS-1:0]    left_stick_x,
  input  wire logic signed [jsbq_pkg::AXIS_BITS-1:0]    left_stick_y,
  input  wire logic signed [jsbq_pkg::AXIS_BITS-1:0]    right_stick_x,
  input  wire logic signed [jsbq_pkg::AXIS_BITS-1:0]    right_stick_y,
  input  wire logic        [jsbq_pkg::GRIP_BITS-1:0]    left_grip_level,
  input  wire logic        [jsbq_pkg::GRIP_BITS-1:0]    right_grip_level,
  input  wire logic        [jsbq_pkg::BTN_BITS-1:0]     button_bits,
  // result channel
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic signed      [jsbq_pkg::AXIS_BITS-1:0]    left_x_filtered,
  output logic signed      [jsbq_pkg::AXIS_BITS-1:0]    left_y_filtered,
  output logic signed      [jsbq_pkg::AXIS_BITS-1:0]    right_x_filtered,
  output logic signed      [jsbq_pkg::AXIS_BITS-1:0]    right_y_filtered,
  output logic                                          stick_hold_flag,
  output logic                                          freeze_flag,
  output logic                                          left_mode_flag,
  output logic                                          right_mode_flag,
  output logic                                          left_grip_flag,
  output logic                                          right_grip_flag,
  // configuration channel
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic        [jsbq_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic        [jsbq_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AB = jsbq_pkg::AXIS_BITS;
  localparam int TB = jsbq_pkg::TIME_BITS;
  localparam int HB = jsbq_pkg::HOLD_CNT_BITS;

  // Configuration registers
  logic [jsbq_pkg::DZ_BITS-1:0]    deadzone_level;
  logic [jsbq_pkg::ALPHA_BITS-1:0] filter_alpha;
  logic [jsbq_pkg::DZ_BITS-1:0]    hold_level;
  logic [HB-1:0]                   hold_count_limit;
  logic [jsbq_pkg::GRIP_BITS-1:0]  grip_level;
  logic [jsbq_pkg::TICK_BITS-1:0]  click_timeout;
  logic [jsbq_pkg::TICK_BITS-1:0]  mode_block_time;

  // Sample register
  logic                               s_valid;
  logic [TB-1:0]                      s_time;
  logic signed [AB-1:0]               s_axis [4];
  logic [jsbq_pkg::GRIP_BITS-1:0]     s_lgrip;
  logic [jsbq_pkg::GRIP_BITS-1:0]     s_rgrip;
  logic [jsbq_pkg::BTN_BITS-1:0]      s_btn;

  // Qualifier state
  logic signed [AB-1:0]               axis_state [4];
  logic signed [AB-1:0]               axis_next  [4];
  logic                               hold_state, hold_state_next;
  logic [HB-1:0]                      hold_counter, hold_counter_next;
  logic                               freeze_state, freeze_state_next;
  logic [jsbq_pkg::BTN_BITS-1:0]      btn_prev;
  logic [1:0]                         mode_bits, mode_bits_next;
  jsbq_pkg::click_state_t             click_x, click_x_next;
  jsbq_pkg::click_state_t             click_a, click_a_next;
  jsbq_pkg::mode_change_t             change, change_mid, change_next;

  logic                               advance;
  logic [jsbq_pkg::MAG_BITS-1:0]      ry_mag;
  logic                               override;
  logic                               counting;
  logic [HB-1:0]                      cnt_inc;
  logic [jsbq_pkg::BTN_BITS-1:0]      rise;

  // Move the sample on whenever the result register is free or being drained.
  assign advance   = s_valid && (!out_valid || out_ready);
  assign in_ready  = !s_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone_level   <= jsbq_pkg::DEADZONE_RESET;
      filter_alpha     <= jsbq_pkg::ALPHA_RESET;
      hold_level       <= jsbq_pkg::HOLD_LEVEL_RESET;
      hold_count_limit <= jsbq_pkg::HOLD_LIMIT_RESET;
      grip_level       <= jsbq_pkg::GRIP_LEVEL_RESET;
      click_timeout    <= jsbq_pkg::CLICK_TMO_RESET;
      mode_block_time  <= jsbq_pkg::BLOCK_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jsbq_pkg::REG_DEADZONE:   deadzone_level   <= cfg_data[jsbq_pkg::DZ_BITS-1:0];
        jsbq_pkg::REG_ALPHA:      filter_alpha     <= cfg_data[jsbq_pkg::ALPHA_BITS-1:0];
        jsbq_pkg::REG_HOLD_LEVEL: hold_level       <= cfg_data[jsbq_pkg::DZ_BITS-1:0];
        jsbq_pkg::REG_HOLD_LIMIT: hold_count_limit <= cfg_data[HB-1:0];
        jsbq_pkg::REG_GRIP_LEVEL: grip_level       <= cfg_data[jsbq_pkg::GRIP_BITS-1:0];
        jsbq_pkg::REG_CLICK_TMO:  click_timeout    <= cfg_data[jsbq_pkg::TICK_BITS-1:0];
        jsbq_pkg::REG_BLOCK_TIME: mode_block_time  <= cfg_data[jsbq_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sample register: valid under reset, payload loaded on each taken beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_time    <= sample_time;
      s_axis[0] <= left_stick_x;
      s_axis[1] <= left_stick_y;
      s_axis[2] <= right_stick_x;
      s_axis[3] <= right_stick_y;
      s_lgrip   <= left_grip_level;
      s_rgrip   <= right_grip_level;
      s_btn     <= button_bits;
    end
  end

  // Strong right-Y deflection: counts toward the hold flip and blanks the other axes.
  assign ry_mag   = jsbq_pkg::axis_mag(s_axis[3]);
  assign override = ry_mag > jsbq_pkg::MAG_BITS'(hold_level);
  // Held: count only past the negative level; not held: only past the positive level.
  assign counting = override && (hold_state ? s_axis[3][AB-1] : !s_axis[3][AB-1]);
  // Saturate the counter, so a limit of all ones never flips the flag.
  assign cnt_inc  = (hold_counter == {HB{1'b1}}) ? hold_counter : hold_counter + 1'b1;

  always_comb begin
    hold_state_next   = hold_state;
    hold_counter_next = '0;
    if (counting) begin
      if (cnt_inc > hold_count_limit) begin
        hold_state_next = !hold_state;
      end else begin
        hold_counter_next = cnt_inc;
      end
    end
  end

  // Axis lanes; right Y is always filtered, the others blank under override.
  for (genvar i = 0; i < 4; i++) begin : g_axis
    jsbq_axis u_axis (
      .x          (s_axis[i]),
      .y_prev     (axis_state[i]),
      .deadzone   (deadzone_level),
      .alpha      (filter_alpha),
      .force_zero ((i != 3) && override),
      .y_next     (axis_next[i])
    );
  end

  // Button edges: Y toggles freeze, X then A feed the click qualifiers.
  assign rise              = s_btn & ~btn_prev;
  assign freeze_state_next = freeze_state ^ rise[jsbq_pkg::BTN_Y];

  jsbq_click u_click_x (
    .press      (rise[jsbq_pkg::BTN_X]),
    .now        (s_time),
    .timeout    (click_timeout),
    .block_time (mode_block_time),
    .click_in   (click_x),
    .change_in  (change),
    .mode_in    (mode_bits[0]),
    .click_out  (click_x_next),
    .change_out (change_mid),
    .mode_out   (mode_bits_next[0])
  );

  // A sees any change that X made on the same sample.
  jsbq_click u_click_a (
    .press      (rise[jsbq_pkg::BTN_A]),
    .now        (s_time),
    .timeout    (click_timeout),
    .block_time (mode_block_time),
    .click_in   (click_a),
    .change_in  (change_mid),
    .mode_in    (mode_bits[1]),
    .click_out  (click_a_next),
    .change_out (change_next),
    .mode_out   (mode_bits_next[1])
  );

  // Commit qualifier state together with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        axis_state[i] <= '0;
      end
      hold_state   <= 1'b1;
      hold_counter <= '0;
      freeze_state <= 1'b0;
      btn_prev     <= '0;
      mode_bits    <= '0;
      click_x      <= '0;
      click_a      <= '0;
      change       <= '0;
    end else if (advance) begin
      for (int i = 0; i < 4; i++) begin
        axis_state[i] <= axis_next[i];
      end
      hold_state   <= hold_state_next;
      hold_counter <= hold_counter_next;
      freeze_state <= freeze_state_next;
      btn_prev     <= s_btn;
      mode_bits    <= mode_bits_next;
      click_x      <= click_x_next;
      click_a      <= click_a_next;
      change       <= change_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_x_filtered  <= axis_next[0];
      left_y_filtered  <= axis_next[1];
      right_x_filtered <= axis_next[2];
      right_y_filtered <= axis_next[3];
      stick_hold_flag  <= hold_state_next;
      freeze_flag      <= freeze_state_next;
      left_mode_flag   <= mode_bits_next[0];
      right_mode_flag  <= mode_bits_next[1];
      left_grip_flag   <= s_lgrip > grip_level;
      right_grip_flag  <= s_rgrip > grip_level;
    end
  end

endmodule
`default_nettype wire

// ===== design/jsbq_axis.sv =====
// One axis lane: deadzone, forced zero and exponential low-pass step.
`default_nettype none
module jsbq_axis (
  input  wire logic signed [jsbq_pkg::AXIS_BITS-1:0]  x,
  input  wire logic signed [jsbq_pkg::AXIS_BITS-1:0]  y_prev,
  input  wire logic        [jsbq_pkg::DZ_BITS-1:0]    deadzone,
  input  wire logic        [jsbq_pkg::ALPHA_BITS-1:0] alpha,
  input  wire logic                                   force_zero,
  output logic signed      [jsbq_pkg::AXIS_BITS-1:0]  y_next
);

  localparam int AB = jsbq_pkg::AXIS_BITS;
  localparam int WB = jsbq_pkg::ALPHA_BITS + 1;
  localparam int PB = WB + 1 + AB + 1;

  logic        [WB-1:0] weight;
  logic signed [AB:0]   delta;
  logic signed [PB-1:0] prod;
  logic signed [PB-1:0] step_full;
  logic signed [AB:0]   sum;
  logic                 outside;

  // y + floor((1 - alpha) * (x - y)), equal to the weighted mix with floor.
  assign weight    = {1'b1, {jsbq_pkg::ALPHA_BITS{1'b0}}} - {1'b0, alpha};
  assign delta     = {x[AB-1], x} - {y_prev[AB-1], y_prev};
  assign prod      = $signed({1'b0, weight}) * delta;
  assign step_full = prod >>> jsbq_pkg::ALPHA_BITS;
  assign sum       = {y_prev[AB-1], y_prev} + step_full[AB:0];
  assign outside   = jsbq_pkg::axis_mag(x) > jsbq_pkg::MAG_BITS'(deadzone);

  always_comb begin
    if (force_zero || !outside) begin
      y_next = '0;
    end else begin
      y_next = sum[AB-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/jsbq_click.sv =====
// Double-click qualifier for one button: window, cooldown and shared change block.
`default_nettype none
module jsbq_click (
  input  wire logic                                 press,
  input  wire logic [jsbq_pkg::TIME_BITS-1:0]       now,
  input  wire logic [jsbq_pkg::TICK_BITS-1:0]       timeout,
  input  wire logic [jsbq_pkg::TICK_BITS-1:0]       block_time,
  input  wire jsbq_pkg::click_state_t               click_in,
  input  wire jsbq_pkg::mode_change_t               change_in,
  input  wire logic                                 mode_in,
  output jsbq_pkg::click_state_t                    click_out,
  output jsbq_pkg::mode_change_t                    change_out,
  output logic                                      mode_out
);

  localparam int TB = jsbq_pkg::TIME_BITS;

  logic [TB-1:0] tmo_ext;
  logic [TB-1:0] blk_ext;
  logic [TB-1:0] since_click;
  logic [TB-1:0] since_change;
  logic [TB:0]   dl_sum;
  logic [TB-1:0] dl;
  logic          cooling;
  logic          first;
  logic          blocked;

  assign tmo_ext      = TB'(timeout);
  assign blk_ext      = TB'(block_time);
  assign since_click  = now - click_in.stamp;
  assign since_change = now - change_in.stamp;
  assign cooling      = click_in.valid && (now < click_in.stamp);
  assign first        = !click_in.valid || (since_click > tmo_ext);
  assign blocked      = change_in.valid &&
                        ((now < change_in.stamp) || (since_change < blk_ext));
  // Saturate the cooldown deadline at the top of the time range.
  assign dl_sum       = {1'b0, now} + {1'b0, tmo_ext};
  assign dl           = dl_sum[TB] ? {TB{1'b1}} : dl_sum[TB-1:0];

  always_comb begin
    click_out  = click_in;
    change_out = change_in;
    mode_out   = mode_in;
    if (press && !cooling) begin
      if (first) begin
        click_out.valid = 1'b1;
        click_out.stamp = now;
      end else begin
        if (!blocked) begin
          mode_out         = !mode_in;
          change_out.valid = 1'b1;
          change_out.stamp = now;
        end
        click_out.stamp = dl;
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/jsbq_checker.sv =====
// Result predictor and scoreboard for the stick and button qualifier, fed from its three channels.
`default_nettype none
module jsbq_checker
  import jsbq_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic        [TIME_BITS-1:0]  sample_time,
  input  wire logic signed [AXIS_BITS-1:0]  left_stick_x,
  input  wire logic signed [AXIS_BITS-1:0]  left_stick_y,
  input  wire logic signed [AXIS_BITS-1:0]  right_stick_x,
  input  wire logic signed [AXIS_BITS-1:0]  right_stick_y,
  input  wire logic        [GRIP_BITS-1:0]  left_grip_level,
  input  wire logic        [GRIP_BITS-1:0]  right_grip_level,
  input  wire logic        [BTN_BITS-1:0]   button_bits,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic signed [AXIS_BITS-1:0]  left_x_filtered,
  input  wire logic signed [AXIS_BITS-1:0]  left_y_filtered,
  input  wire logic signed [AXIS_BITS-1:0]  right_x_filtered,
  input  wire logic signed [AXIS_BITS-1:0]  right_y_filtered,
  input  wire logic                         stick_hold_flag,
  input  wire logic                         freeze_flag,
  input  wire logic                         left_mode_flag,
  input  wire logic                         right_mode_flag,
  input  wire logic                         left_grip_flag,
  input  wire logic                         right_grip_flag,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic        [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_BITS-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending
);

  localparam int DUE_BITS = TIME_BITS + 1;

  typedef struct {
    logic signed [AXIS_BITS-1:0] lx;
    logic signed [AXIS_BITS-1:0] ly;
    logic signed [AXIS_BITS-1:0] rx;
    logic signed [AXIS_BITS-1:0] ry;
    logic                        hold;
    logic                        freeze;
    logic                        lmode;
    logic                        rmode;
    logic                        lgrip;
    logic                        rgrip;
  } stick_result_t;

  logic [DZ_BITS-1:0]          dz_lvl;
  logic [ALPHA_BITS-1:0]       alpha;
  logic [DZ_BITS-1:0]          hold_lvl;
  logic [HOLD_CNT_BITS-1:0]    hold_lim;
  logic [GRIP_BITS-1:0]        grip_lvl;
  logic [TICK_BITS-1:0]        click_tmo;
  logic [TICK_BITS-1:0]        block_time;

  logic signed [AXIS_BITS-1:0] axis_y [4];
  logic                        held;
  logic [HOLD_CNT_BITS-1:0]    hold_cnt;
  logic                        frozen;
  logic [BTN_BITS-1:0]         btn_last;
  logic [1:0]                  arm_mode;
  logic [TIME_BITS-1:0]        click_stamp [2];
  logic [1:0]                  click_armed;
  logic [TIME_BITS-1:0]        change_stamp;
  logic                        change_seen;

  stick_result_t result_q[$];
  int            fails = 0;

  // Deadzone, then y = floor((a*y + (65536-a)*x) / 65536).
  function automatic logic signed [AXIS_BITS-1:0] condition_axis(
      input logic signed [AXIS_BITS-1:0] prev, input logic signed [AXIS_BITS-1:0] x);
    int     mag;
    longint acc;
    mag = (x < 0) ? -int'(x) : int'(x);
    if (mag <= int'(dz_lvl)) begin
      return '0;
    end
    acc = longint'(alpha) * longint'(prev) + (longint'(65536) - longint'(alpha)) * longint'(x);
    return AXIS_BITS'(acc >>> 16);
  endfunction

  task automatic click(input int side, input logic [TIME_BITS-1:0] now);
    logic                blocked;
    logic [DUE_BITS-1:0] due;
    // still inside the cooldown of the last click pair
    if (click_armed[side] && now < click_stamp[side]) begin
      return;
    end
    if (!click_armed[side] || now - click_stamp[side] > TIME_BITS'(click_tmo)) begin
      click_stamp[side] = now;
      click_armed[side] = 1'b1;
      return;
    end
    blocked = change_seen &&
              (now < change_stamp || now - change_stamp < TIME_BITS'(block_time));
    if (!blocked) begin
      arm_mode[side] = ~arm_mode[side];
      change_stamp   = now;
      change_seen    = 1'b1;
    end
    due = {1'b0, now} + DUE_BITS'(click_tmo);
    click_stamp[side] = due[TIME_BITS] ? '1 : due[TIME_BITS-1:0];
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    stick_result_t r;
    int            ry;
    int            hl;
    logic          counting;
    if (rst) begin
      dz_lvl      = DEADZONE_RESET;
      alpha       = ALPHA_RESET;
      hold_lvl    = HOLD_LEVEL_RESET;
      hold_lim    = HOLD_LIMIT_RESET;
      grip_lvl    = GRIP_LEVEL_RESET;
      click_tmo   = CLICK_TMO_RESET;
      block_time  = BLOCK_TIME_RESET;
      for (int i = 0; i < 4; i++) begin
        axis_y[i] = '0;
      end
      held           = 1'b1;
      hold_cnt       = '0;
      frozen         = 1'b0;
      btn_last       = '0;
      arm_mode       = '0;
      click_stamp[0] = '0;
      click_stamp[1] = '0;
      click_armed    = '0;
      change_stamp   = '0;
      change_seen    = 1'b0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEADZONE:   dz_lvl     = cfg_data[DZ_BITS-1:0];
          REG_ALPHA:      alpha      = cfg_data[ALPHA_BITS-1:0];
          REG_HOLD_LEVEL: hold_lvl   = cfg_data[DZ_BITS-1:0];
          REG_HOLD_LIMIT: hold_lim   = cfg_data[HOLD_CNT_BITS-1:0];
          REG_GRIP_LEVEL: grip_lvl   = cfg_data[GRIP_BITS-1:0];
          REG_CLICK_TMO:  click_tmo  = cfg_data[TICK_BITS-1:0];
          REG_BLOCK_TIME: block_time = cfg_data[TICK_BITS-1:0];
          default: ;
        endcase
      end

      // retire before predicting: a result beat never belongs to a sample taken this edge
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, actual axes %0d %0d %0d %0d",
                   $time, left_x_filtered, left_y_filtered, right_x_filtered,
                   right_y_filtered);
        end else begin
          r = result_q.pop_front();
          check_field("left_x_filtered", r.lx, left_x_filtered);
          check_field("left_y_filtered", r.ly, left_y_filtered);
          check_field("right_x_filtered", r.rx, right_x_filtered);
          check_field("right_y_filtered", r.ry, right_y_filtered);
          check_field("stick_hold_flag", r.hold, stick_hold_flag);
          check_field("freeze_flag", r.freeze, freeze_flag);
          check_field("left_mode_flag", r.lmode, left_mode_flag);
          check_field("right_mode_flag", r.rmode, right_mode_flag);
          check_field("left_grip_flag", r.lgrip, left_grip_flag);
          check_field("right_grip_flag", r.rgrip, right_grip_flag);
        end
      end

      if (in_valid && in_ready) begin
        ry = int'(right_stick_y);
        hl = int'(hold_lvl);
        counting = held ? (ry < -hl) : (ry > hl);
        if (counting) begin
          if (hold_cnt != '1) begin
            hold_cnt++;
          end
          if (hold_cnt > hold_lim) begin
            held     = ~held;
            hold_cnt = '0;
          end
        end else begin
          hold_cnt = '0;
        end

        if (ry > hl || ry < -hl) begin
          axis_y[0] = '0;
          axis_y[1] = '0;
          axis_y[2] = '0;
          axis_y[3] = condition_axis(axis_y[3], right_stick_y);
        end else begin
          axis_y[0] = condition_axis(axis_y[0], left_stick_x);
          axis_y[1] = condition_axis(axis_y[1], left_stick_y);
          axis_y[2] = condition_axis(axis_y[2], right_stick_x);
          axis_y[3] = condition_axis(axis_y[3], right_stick_y);
        end

        if (button_bits[BTN_Y] && !btn_last[BTN_Y]) begin
          frozen = ~frozen;
        end
        if (button_bits[BTN_X] && !btn_last[BTN_X]) begin
          click(0, sample_time);
        end
        if (button_bits[BTN_A] && !btn_last[BTN_A]) begin
          click(1, sample_time);
        end
        btn_last = button_bits;

        r.lx     = axis_y[0];
        r.ly     = axis_y[1];
        r.rx     = axis_y[2];
        r.ry     = axis_y[3];
        r.hold   = held;
        r.freeze = frozen;
        r.lmode  = arm_mode[0];
        r.rmode  = arm_mode[1];
        r.lgrip  = left_grip_level > grip_lvl;
        r.rgrip  = right_grip_level > grip_lvl;
        result_q.push_back(r);
      end
    end
    pending    <= result_q.size();
    fail_count <= fails;
  end

endmodule
`default_nettype wire

// ===== test/joystick_stick_and_button_qualifier_tb.sv =====
// Testbench top for the stick and button qualifier: clock, reset, stimulus and verdict.
`default_nettype none
module joystick_stick_and_button_qualifier_tb;
  import jsbq_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] UNUSED_REG_INDEX = 3'd7;
  localparam logic [BTN_BITS-1:0] RELEASED = '0;
  localparam logic [BTN_BITS-1:0] PRESS_X  = BTN_BITS'(1 << BTN_X);
  localparam logic [BTN_BITS-1:0] PRESS_Y  = BTN_BITS'(1 << BTN_Y);
  localparam logic [BTN_BITS-1:0] PRESS_A  = BTN_BITS'(1 << BTN_A);
  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

  // Right stick Y behavior for a run of random samples.
  typedef enum int {STANCE_FREE, STANCE_EDGE, STANCE_UP, STANCE_DOWN} stance_t;

  typedef struct {
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_beat_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic        [TIME_BITS-1:0]   sample_time = '0;
  logic signed [AXIS_BITS-1:0]   left_stick_x = '0;
  logic signed [AXIS_BITS-1:0]   left_stick_y = '0;
  logic signed [AXIS_BITS-1:0]   right_stick_x = '0;
  logic signed [AXIS_BITS-1:0]   right_stick_y = '0;
  logic        [GRIP_BITS-1:0]   left_grip_level = '0;
  logic        [GRIP_BITS-1:0]   right_grip_level = '0;
  logic        [BTN_BITS-1:0]    button_bits = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [AXIS_BITS-1:0]   left_x_filtered;
  logic signed [AXIS_BITS-1:0]   left_y_filtered;
  logic signed [AXIS_BITS-1:0]   right_x_filtered;
  logic signed [AXIS_BITS-1:0]   right_y_filtered;
  logic                          stick_hold_flag;
  logic                          freeze_flag;
  logic                          left_mode_flag;
  logic                          right_mode_flag;
  logic                          left_grip_flag;
  logic                          right_grip_flag;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic        [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic        [CFG_DATA_BITS-1:0] cfg_data = '0;
  int                            fail_count;
  int                            pending;

  // stimulus shaping state
  logic                          calm = 1'b0;
  int                            stall_left = 0;
  logic        [TIME_BITS-1:0]   now_t = '0;
  int unsigned                   tick_step = 1000;
  stance_t                       stance = STANCE_FREE;
  int                            stance_left = 0;
  logic        [BTN_BITS-1:0]    btn_state = '0;
  int unsigned                   cur_dz = 3277;
  int unsigned                   cur_hl = 26214;
  int unsigned                   cur_lim = 100;
  int unsigned                   cur_grip = 49152;
  int                            sent = 0;
  int                            cfg_beats = 0;
  int                            settings_used = 0;
  cfg_beat_t                     cfg_q[$];

  always #5 clk = ~clk;

  joystick_stick_and_button_qualifier u_top (.*);

  jsbq_checker u_check (.*);

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(8, 40));
  endfunction

  // Pick an axis value: full range, around the deadzone, the rails, or near center.
  function automatic logic signed [AXIS_BITS-1:0] pick_axis();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: begin
        v = int'(cur_dz) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      2: v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 2000)) - 1000;
    endcase
    return AXIS_BITS'(v);
  endfunction

  // Right Y follows the current stance so hold runs build up over many samples.
  function automatic logic signed [AXIS_BITS-1:0] pick_right_y();
    int v;
    int hl;
    hl = int'(cur_hl);
    case (stance)
      STANCE_UP:
        v = (hl < 32767) ? hl + 1 + int'($urandom_range(0, 32766 - hl)) : 32767;
      STANCE_DOWN:
        v = -hl - 1 - int'($urandom_range(0, 32767 - hl));
      STANCE_EDGE: begin
        v = hl + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      default: return pick_axis();
    endcase
    return AXIS_BITS'(v);
  endfunction

  function automatic logic [GRIP_BITS-1:0] pick_grip();
    if ($urandom_range(0, 1) == 1) begin
      return GRIP_BITS'($urandom_range(0, 65535));
    end
    return GRIP_BITS'(int'(cur_grip) + int'($urandom_range(0, 2)) - 1);
  endfunction

  // Offer one sample beat, hold it until taken, then maybe idle.
  task automatic send(input logic [TIME_BITS-1:0] t,
                      input logic signed [AXIS_BITS-1:0] lx, input logic signed [AXIS_BITS-1:0] ly,
                      input logic signed [AXIS_BITS-1:0] rx, input logic signed [AXIS_BITS-1:0] ry,
                      input logic [GRIP_BITS-1:0] lg, input logic [GRIP_BITS-1:0] rg,
                      input logic [BTN_BITS-1:0] b);
    int gap;
    sample_time      <= t;
    left_stick_x     <= lx;
    left_stick_y     <= ly;
    right_stick_x    <= rx;
    right_stick_y    <= ry;
    left_grip_level  <= lg;
    right_grip_level <= rg;
    button_bits      <= b;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] d);
    cfg_beat_t b;
    b.idx  = idx;
    b.data = d;
    cfg_q.push_back(b);
  endtask

  // Idle the block, then write every register back to back, with any queued extra beats first.
  task automatic configure(input logic [31:0] dz, input logic [31:0] al, input logic [31:0] hl,
                           input logic [31:0] lim, input logic [31:0] grip,
                           input logic [31:0] tmo, input logic [31:0] blk,
                           input int unsigned step);
    cfg_beat_t b;
    settle();
    push_cfg(REG_DEADZONE, dz);
    push_cfg(REG_ALPHA, al);
    push_cfg(REG_HOLD_LEVEL, hl);
    push_cfg(REG_HOLD_LIMIT, lim);
    push_cfg(REG_GRIP_LEVEL, grip);
    push_cfg(REG_CLICK_TMO, tmo);
    push_cfg(REG_BLOCK_TIME, blk);
    while (cfg_q.size() != 0) begin
      b = cfg_q.pop_front();
      cfg_index <= b.idx;
      cfg_data  <= b.data;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      cfg_beats++;
    end
    cfg_valid <= 1'b0;
    cur_dz    = int'(dz[DZ_BITS-1:0]);
    cur_hl    = int'(hl[DZ_BITS-1:0]);
    cur_lim   = int'(lim[HOLD_CNT_BITS-1:0]);
    cur_grip  = int'(grip[GRIP_BITS-1:0]);
    tick_step = step;
    settings_used++;
  endtask

  // One random sample: timestamp mostly advances by a step scaled to the click window, at times
  // jumps anywhere; buttons mostly flip one bit at a time so press and release pairs form.
  task automatic random_sample();
    if (stance_left == 0) begin
      stance      = stance_t'($urandom_range(0, 3));
      stance_left = int'($urandom_range(1, cur_lim + 20));
    end
    stance_left--;
    if ($urandom_range(0, 63) == 0) begin
      now_t = TIME_BITS'({$urandom(), $urandom()});
    end else begin
      now_t = now_t + TIME_BITS'($urandom_range(0, tick_step));
    end
    if ($urandom_range(0, 15) == 0) begin
      btn_state = BTN_BITS'($urandom_range(0, 7));
    end else if ($urandom_range(0, 1) == 1) begin
      btn_state = btn_state ^ BTN_BITS'(1 << $urandom_range(0, BTN_BITS - 1));
    end
    send(now_t, pick_axis(), pick_axis(), pick_axis(), pick_right_y(),
         pick_grip(), pick_grip(), btn_state);
  endtask

  // Result side: stall at random, with calm stretches where no new stall starts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = gap_len();
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int          t;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset register values.
    // zero sample, then the rails and the grip threshold
    send(48'd0, 0, 0, 0, 0, 0, 0, RELEASED);
    send(48'd10, 32767, -32768, 32767, 0, 65535, 65535, RELEASED);
    send(48'd20, -32768, 32767, -32768, 100, 49152, 49153, RELEASED);
    // axes exactly at the deadzone and one past it
    send(48'd30, 3277, -3277, 3278, -3278, 0, 49152, RELEASED);
    // right Y at the hold level: no override
    send(48'd40, 1000, -1000, 1000, 26214, 100, 100, RELEASED);
    // right Y past the level both ways: override, and counting while held
    send(48'd50, 20000, 20000, 20000, 26215, 100, 100, RELEASED);
    send(48'd60, 20000, 20000, 20000, -26215, 100, 100, RELEASED);
    send(48'd70, -20000, 5000, 5000, -32768, 100, 100, RELEASED);
    send(48'd80, 5000, 5000, 5000, 0, 100, 100, RELEASED);
    // freeze toggle, then a left double-click that changes mode
    send(48'd1_000_000, 0, 0, 0, 0, 0, 0, PRESS_Y);
    send(48'd1_000_010, 0, 0, 0, 0, 0, 0, RELEASED);
    send(48'd1_000_020, 0, 0, 0, 0, 0, 0, PRESS_X);
    send(48'd1_000_030, 0, 0, 0, 0, 0, 0, RELEASED);
    send(48'd1_100_000, 0, 0, 0, 0, 0, 0, PRESS_X);
    send(48'd1_100_010, 0, 0, 0, 0, 0, 0, RELEASED);
    // press inside the cooldown: ignored
    send(48'd1_200_000, 0, 0, 0, 0, 0, 0, PRESS_X);
    // right double-click inside the change block: refused
    send(48'd1_200_010, 0, 0, 0, 0, 0, 0, PRESS_A | PRESS_Y);
    send(48'd1_200_020, 0, 0, 0, 0, 0, 0, RELEASED);
    send(48'd1_300_000, 0, 0, 0, 0, 0, 0, PRESS_A);
    send(48'd1_300_010, 0, 0, 0, 0, 0, 0, RELEASED);
    // near the top of the time range: the cooldown deadline saturates
    send(TIME_TOP - 48'hFFFF, 0, 0, 0, 0, 0, 0, PRESS_X);
    send(TIME_TOP - 48'hFFF0, 0, 0, 0, 0, 0, 0, RELEASED);
    send(TIME_TOP - 48'h0FFF, 0, 0, 0, 0, 0, 0, PRESS_X | PRESS_A);
    send(TIME_TOP, 0, 0, 0, 0, 0, 0, RELEASED);
    // time jumps back below the saturated deadline: press ignored
    send(48'd100, 0, 0, 0, 0, 0, 0, PRESS_X);

    now_t = 48'd2_000_000;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: configure(3277, 32768, 26214, 100, 49152, 300000, 5000000, 200000);
        1: configure(0, 0, 0, 0, 0, 0, 0, 2);
        2: configure(32'h7FFF, 32'hFFFF, 32'h7FFF, 32'hFF, 32'hFFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'd2_000_000_000);
        3: configure($urandom_range(0, 8000), $urandom(), $urandom_range(1000, 20000), 0,
                     $urandom_range(0, 65535), 300, 1000, 200);
        4: begin
          // junk above each register's width, and a beat to an index with no register
          push_cfg(UNUSED_REG_INDEX, $urandom());
          configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    2000, 6000, 800);
        end
        default: begin
          t = int'($urandom_range(0, 5000));
          configure($urandom_range(0, 32767), $urandom(), $urandom_range(0, 32767),
                    $urandom_range(0, 40), $urandom_range(0, 65535), t,
                    $urandom_range(0, 20000), t / 2 + 2);
        end
      endcase
      for (int i = 0; i < 122; i++) begin
        if (i % 30 == 0) begin
          calm <= ($urandom_range(0, 3) == 0);
        end
        random_sample();
      end
    end

    settle();
    $display("Summary: %0d samples under %0d register settings, %0d register beats", sent,
             settings_used, cfg_beats);
    $display("  incl. zero and full-scale registers, wide data, time jumps, saturated deadlines.");
    if (fail_count == 0) begin
      $display("joystick_stick_and_button_qualifier test passed");
    end else begin
      $display("joystick_stick_and_button_qualifier test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("joystick_stick_and_button_qualifier test failed");
    $finish;
  end

endmodule
`default_nettype wire
